FILE: sv/irr_pkg.sv
// ----------------------------------------------------------------------------
// irr_pkg: shared types and constants of the irrigation decision block
// Payload structs, configuration register indexes, reset values and the
// fixed thresholds of risk scoring and need evaluation.
// ----------------------------------------------------------------------------
package irr_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_TOP_SOIL_MIN       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROOT_SOIL_MIN      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROOT_SOIL_MAX      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TOP_LAYER_ENABLED  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROOT_LAYER_ENABLED = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_WEATHER_ADJUST     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_AUTOMATIC_MODE     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_TOGGLE_MS      = 3'd7;

   localparam logic [13:0] RST_TOP_SOIL_MIN  = 14'd2500;
   localparam logic [13:0] RST_ROOT_SOIL_MIN = 14'd3500;
   localparam logic [13:0] RST_ROOT_SOIL_MAX = 14'd7000;
   localparam logic [31:0] RST_MIN_TOGGLE_MS = 32'd60000;

   // pest scoring
   localparam logic [13:0]        PEST_HUM      = 14'd8500;
   localparam logic [6:0]         PEST_LEAF     = 7'd60;
   localparam logic signed [14:0] PEST_T_LO     = 15'sd2000;
   localparam logic signed [14:0] PEST_T_HI     = 15'sd3000;
   localparam logic [13:0]        PEST_ROOT     = 14'd8000;
   localparam logic [6:0]         PEST_PTS_HUM  = 7'd30;
   localparam logic [6:0]         PEST_PTS_LEAF = 7'd35;
   localparam logic [6:0]         PEST_PTS_TEMP = 7'd20;
   localparam logic [6:0]         PEST_PTS_ROOT = 7'd10;

   // disease scoring
   localparam logic signed [14:0] DIS_HI_T_LO  = 15'sd2000;
   localparam logic signed [14:0] DIS_HI_T_HI  = 15'sd2800;
   localparam logic [13:0]        DIS_HI_HUM   = 14'd9000;
   localparam logic signed [14:0] DIS_MID_T_LO = 15'sd1800;
   localparam logic signed [14:0] DIS_MID_T_HI = 15'sd3000;
   localparam logic [13:0]        DIS_MID_HUM  = 14'd8000;
   localparam logic [13:0]        DIS_LOW_HUM  = 14'd7500;
   localparam logic [6:0]         DIS_LEAF     = 7'd70;
   localparam logic [6:0]         DIS_PTS_HI   = 7'd80;
   localparam logic [6:0]         DIS_PTS_MID  = 7'd50;
   localparam logic [6:0]         DIS_PTS_LOW  = 7'd25;
   localparam logic [6:0]         DIS_PTS_LEAF = 7'd15;

   localparam logic [6:0] RISK_MAX = 7'd100;

   // water decisions
   localparam logic [13:0]        EXCESS_ROOT = 14'd8500;
   localparam logic [13:0]        EXCESS_TOP  = 14'd9000;
   localparam logic [15:0]        RAIN_STOP   = 16'd20;
   localparam logic [13:0]        HUM_HOLD    = 14'd9000;
   localparam logic signed [15:0] ROOT_MARGIN = 16'sd500;

   typedef struct packed {
      logic signed [14:0] air_temp;
      logic [13:0]        air_humidity;
      logic [6:0]         leaf_wetness;
      logic [13:0]        top_soil;
      logic [13:0]        root_soil;
      logic [15:0]        rainfall;
      logic [31:0]        time_ms;
   } req_type;

   typedef struct packed {
      logic [6:0] pest_risk;
      logic [6:0] disease_risk;
      logic       excess_water;
      logic       watering_needed;
      logic       valve_open;
      logic       valve_changed;
   } rsp_type;

   typedef struct packed {
      logic [13:0] top_soil_min;
      logic [13:0] root_soil_min;
      logic [13:0] root_soil_max;
      logic        top_layer_enabled;
      logic        root_layer_enabled;
      logic        weather_adjust;
      logic        automatic_mode;
      logic [31:0] min_toggle_ms;
   } cfg_type;

   typedef struct packed {
      logic excess_water;
      logic watering_needed;
      logic valve_open;
      logic valve_changed;
   } ctl_type;

endpackage

FILE: sv/irr_if.sv
// ----------------------------------------------------------------------------
// irr_if: valid/ready channels of the irrigation decision block
// Sample channel and result channel, each with source and sink views.
// ----------------------------------------------------------------------------
interface irr_req_if;
   logic             valid;
   logic             ready;
   irr_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface irr_rsp_if;
   logic             valid;
   logic             ready;
   irr_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: sv/irr_csr.sv
// ----------------------------------------------------------------------------
// irr_csr: configuration registers
// Write-only register file decoded from the plain write port.
// ----------------------------------------------------------------------------
module irr_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [irr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [irr_pkg::CSR_DATA_W-1:0] csr_wdata,
   output irr_pkg::cfg_type               cfg
);

   irr_pkg::cfg_type cfg_ff;
   irr_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            irr_pkg::CSR_TOP_SOIL_MIN:       cfg_in.top_soil_min       = csr_wdata[13:0];
            irr_pkg::CSR_ROOT_SOIL_MIN:      cfg_in.root_soil_min      = csr_wdata[13:0];
            irr_pkg::CSR_ROOT_SOIL_MAX:      cfg_in.root_soil_max      = csr_wdata[13:0];
            irr_pkg::CSR_TOP_LAYER_ENABLED:  cfg_in.top_layer_enabled  = csr_wdata[0];
            irr_pkg::CSR_ROOT_LAYER_ENABLED: cfg_in.root_layer_enabled = csr_wdata[0];
            irr_pkg::CSR_WEATHER_ADJUST:     cfg_in.weather_adjust     = csr_wdata[0];
            irr_pkg::CSR_AUTOMATIC_MODE:     cfg_in.automatic_mode     = csr_wdata[0];
            irr_pkg::CSR_MIN_TOGGLE_MS:      cfg_in.min_toggle_ms      = csr_wdata[31:0];
            default:                         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.top_soil_min       <= irr_pkg::RST_TOP_SOIL_MIN;
         cfg_ff.root_soil_min      <= irr_pkg::RST_ROOT_SOIL_MIN;
         cfg_ff.root_soil_max      <= irr_pkg::RST_ROOT_SOIL_MAX;
         cfg_ff.top_layer_enabled  <= 1'b1;
         cfg_ff.root_layer_enabled <= 1'b1;
         cfg_ff.weather_adjust     <= 1'b1;
         cfg_ff.automatic_mode     <= 1'b1;
         cfg_ff.min_toggle_ms      <= irr_pkg::RST_MIN_TOGGLE_MS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: sv/irr_risk.sv
// ----------------------------------------------------------------------------
// irr_risk: pest and disease risk scoring
// Threshold-based scores from temperature, humidity, leaf wetness and root
// moisture, saturated at 100.
// ----------------------------------------------------------------------------
module irr_risk (
   input  irr_pkg::req_type item,
   output logic [6:0]       pest_risk,
   output logic [6:0]       disease_risk
);

   logic [6:0] pest_sum;
   logic [6:0] dis_base;
   logic [6:0] dis_sum;

   always_comb begin
      pest_sum = '0;
      if (item.air_humidity > irr_pkg::PEST_HUM) pest_sum = pest_sum + irr_pkg::PEST_PTS_HUM;
      if (item.leaf_wetness > irr_pkg::PEST_LEAF) pest_sum = pest_sum + irr_pkg::PEST_PTS_LEAF;
      if (item.air_temp >= irr_pkg::PEST_T_LO && item.air_temp <= irr_pkg::PEST_T_HI)
         pest_sum = pest_sum + irr_pkg::PEST_PTS_TEMP;
      if (item.root_soil > irr_pkg::PEST_ROOT) pest_sum = pest_sum + irr_pkg::PEST_PTS_ROOT;

      if (item.air_temp >= irr_pkg::DIS_HI_T_LO && item.air_temp <= irr_pkg::DIS_HI_T_HI &&
          item.air_humidity > irr_pkg::DIS_HI_HUM) begin
         dis_base = irr_pkg::DIS_PTS_HI;
      end else if (item.air_temp >= irr_pkg::DIS_MID_T_LO &&
                   item.air_temp <= irr_pkg::DIS_MID_T_HI &&
                   item.air_humidity > irr_pkg::DIS_MID_HUM) begin
         dis_base = irr_pkg::DIS_PTS_MID;
      end else if (item.air_humidity > irr_pkg::DIS_LOW_HUM) begin
         dis_base = irr_pkg::DIS_PTS_LOW;
      end else begin
         dis_base = '0;
      end
      dis_sum = dis_base;
      if (item.leaf_wetness > irr_pkg::DIS_LEAF) dis_sum = dis_base + irr_pkg::DIS_PTS_LEAF;
   end

   assign pest_risk    = (pest_sum > irr_pkg::RISK_MAX) ? irr_pkg::RISK_MAX : pest_sum;
   assign disease_risk = (dis_sum > irr_pkg::RISK_MAX) ? irr_pkg::RISK_MAX : dis_sum;

endmodule

FILE: sv/irr_ctrl.sv
// ----------------------------------------------------------------------------
// irr_ctrl: watering need and irrigation toggle state
// Evaluates need and stop, applies the minimum toggle interval and keeps
// the irrigation, need and valve state. State advances on each step.
// ----------------------------------------------------------------------------
module irr_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  irr_pkg::cfg_type cfg,
   input  irr_pkg::req_type item,
   output irr_pkg::ctl_type ctl
);

   logic        irrigating_ff, irrigating_in;
   logic [31:0] last_toggle_ff, last_toggle_in;
   logic        valve_ff, valve_in;
   logic        need_ff, need_in;

   logic        need_a;
   logic        rain_hit;
   logic        hum_hold;
   logic        need;
   logic        stop;
   logic [31:0] elapsed;
   logic        open;
   logic        irr_next;
   logic        valve_pre;

   always_comb begin
      need_a = (cfg.root_layer_enabled && item.root_soil < cfg.root_soil_min) ||
               (cfg.top_layer_enabled && item.top_soil < cfg.top_soil_min);
      rain_hit = cfg.weather_adjust && item.rainfall > irr_pkg::RAIN_STOP;
      stop = (cfg.root_layer_enabled && item.root_soil > cfg.root_soil_max) || rain_hit;
      hum_hold = cfg.weather_adjust && item.air_humidity > irr_pkg::HUM_HOLD &&
                 ($signed({2'b00, item.root_soil}) >
                  ($signed({2'b00, cfg.root_soil_min}) - irr_pkg::ROOT_MARGIN));
      need = need_a && !rain_hit && !hum_hold;

      elapsed = item.time_ms - last_toggle_ff;
      open = elapsed >= cfg.min_toggle_ms;

      if (!irrigating_ff && need) begin
         irr_next = 1'b1;
      end else if (irrigating_ff && stop) begin
         irr_next = 1'b0;
      end else begin
         irr_next = irrigating_ff;
      end

      irrigating_in  = open ? irr_next : irrigating_ff;
      last_toggle_in = (open && irr_next != irrigating_ff) ? item.time_ms : last_toggle_ff;
      need_in        = open ? need : need_ff;
      valve_pre      = open ? irr_next : valve_ff;
      valve_in       = cfg.automatic_mode && valve_pre;

      ctl.excess_water    = item.root_soil > irr_pkg::EXCESS_ROOT ||
                            item.top_soil > irr_pkg::EXCESS_TOP;
      ctl.watering_needed = need_in;
      ctl.valve_open      = valve_in;
      ctl.valve_changed   = cfg.automatic_mode && (valve_in != valve_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         irrigating_ff  <= 1'b0;
         last_toggle_ff <= '0;
         valve_ff       <= 1'b0;
         need_ff        <= 1'b0;
      end else if (step) begin
         irrigating_ff  <= irrigating_in;
         last_toggle_ff <= last_toggle_in;
         valve_ff       <= valve_in;
         need_ff        <= need_in;
      end
   end

endmodule

FILE: sv/irrigation_decision_with_risk_top.sv
// ----------------------------------------------------------------------------
// irrigation_decision_with_risk_top: irrigation decision with risk scoring
// Each sample on req_ch (temperature, humidity, leaf wetness, top and root
// soil moisture, rainfall, millisecond time) yields one result on rsp_ch:
// pest and disease risk, excess water flag, watering need, valve request
// and a valve change flag.
// A transfer on req_ch lands in the input register; the scoring and toggle
// logic run from it, and the result is then loaded into the output register.
// One sample per cycle is sustained: both the input and output registers
// advance together whenever the output register is empty or being taken.
// When the receiver holds rsp_ch.ready low the result stays put, one more
// sample waits in the input register, and req_ch.ready then drops.
// Configuration is written through csr_we/csr_index/csr_wdata; the user must
// do so only while no sample is in flight, which the block does not enforce.
// The new value applies from the next sample.
// Synchronous reset empties both registers, clears the irrigation state
// and the toggle time, and restores the register defaults.
// ----------------------------------------------------------------------------
module irrigation_decision_with_risk_top (
   input  logic                           clock,
   input  logic                           reset,
   irr_req_if.sink                        req_ch,
   irr_rsp_if.source                      rsp_ch,
   input  logic                           csr_we,
   input  logic [irr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [irr_pkg::CSR_DATA_W-1:0] csr_wdata
);

   irr_pkg::cfg_type cfg;
   irr_pkg::ctl_type ctl;

   logic             in_valid_ff, in_valid_in;
   irr_pkg::req_type in_data_ff;
   logic             out_valid_ff, out_valid_in;
   irr_pkg::rsp_type out_data_ff, out_data_in;

   logic       advance;
   logic       step;
   logic [6:0] pest_risk;
   logic [6:0] disease_risk;

   irr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   irr_risk u_risk (
      .item         (in_data_ff),
      .pest_risk    (pest_risk),
      .disease_risk (disease_risk)
   );

   irr_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .cfg   (cfg),
      .item  (in_data_ff),
      .ctl   (ctl)
   );

   assign advance      = !out_valid_ff || rsp_ch.ready;
   assign step         = in_valid_ff && advance;
   assign req_ch.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in  = req_ch.ready ? req_ch.valid : in_valid_ff;
      out_valid_in = advance ? in_valid_ff : out_valid_ff;
      out_data_in.pest_risk       = pest_risk;
      out_data_in.disease_risk    = disease_risk;
      out_data_in.excess_water    = ctl.excess_water;
      out_data_in.watering_needed = ctl.watering_needed;
      out_data_in.valve_open      = ctl.valve_open;
      out_data_in.valve_changed   = ctl.valve_changed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_data_ff <= req_ch.data;
      end
      if (step) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.data  = out_data_ff;

endmodule

FILE: sv/irr_checker.sv
// ----------------------------------------------------------------------------
// irr_checker: port-level checks of the irrigation decision block
// Result hold under stall, score range, fill latency and ready when empty.
// ----------------------------------------------------------------------------
module irr_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input irr_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_score_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.pest_risk <= irr_pkg::RISK_MAX &&
                    rsp_data.disease_risk <= irr_pkg::RISK_MAX)
      else $error("risk score above saturation");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready ##1 rsp_ready |=> rsp_valid)
      else $error("result missing after transfer");

   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("sample not taken while output empty");

endmodule

bind irrigation_decision_with_risk_top irr_checker u_irr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_data  (rsp_ch.data)
);

FILE: tb/tb_irrigation_decision_with_risk_top.sv
// ----------------------------------------------------------------------------
// tb_irrigation_decision_with_risk_top: self-checking bench of the irrigation block
// A short directed sample list runs first. Some of its rows carry hand-computed
// results; the rest are scored by a behavioral decision predictor. Random
// samples follow over several register settings, including the threshold
// extremes, manual mode, and zero and maximum toggle intervals. Both
// channels stall at random, and the result side holds off once for a long
// stretch. Every result transfer is compared field by field.
// ----------------------------------------------------------------------------
module tb_irrigation_decision_with_risk_top;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 60;

   typedef struct {
      irr_pkg::req_type sample;
      bit               typed;
      irr_pkg::rsp_type result;
   } sample_row_type;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           csr_we;
   logic [irr_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [irr_pkg::CSR_DATA_W-1:0] csr_wdata;

   irr_req_if req_ch ();
   irr_rsp_if rsp_ch ();

   irrigation_decision_with_risk_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor state and settings
   irr_pkg::cfg_type model_cfg;
   bit               model_irrigating;
   logic [31:0]      model_last_toggle;
   bit               model_valve;
   bit               model_need;
   bit               model_excess;

   irr_pkg::rsp_type expected_decisions[$];
   sample_row_type   directed_rows[$];
   logic [31:0]      sample_time;
   int               items_sent = 0;
   int               mismatches = 0;
   int               cycle_count = 0;
   int               hold_left = 0;
   bit               hold_done = 0;
   wire              steady = (items_sent >= 500) && (items_sent < 700);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic irr_pkg::cfg_type make_cfg(int ts_min, int rt_min, int rt_max,
                                                 bit top_en, bit root_en, bit weather,
                                                 bit auto_on, logic [31:0] toggle_ms);
      irr_pkg::cfg_type c;
      c.top_soil_min       = 14'(ts_min);
      c.root_soil_min      = 14'(rt_min);
      c.root_soil_max      = 14'(rt_max);
      c.top_layer_enabled  = top_en;
      c.root_layer_enabled = root_en;
      c.weather_adjust     = weather;
      c.automatic_mode     = auto_on;
      c.min_toggle_ms      = toggle_ms;
      return c;
   endfunction

   function automatic irr_pkg::rsp_type predict_decision(irr_pkg::req_type s);
      irr_pkg::rsp_type r;
      int               temp;
      int               pest;
      int               dis;
      bit               need;
      bit               stop;
      bit               prior;
      logic [31:0]      elapsed;
      temp = $signed(s.air_temp);
      pest = 0;
      if (s.air_humidity > 14'd8500) pest += 30;
      if (s.leaf_wetness > 7'd60) pest += 35;
      if (temp >= 2000 && temp <= 3000) pest += 20;
      if (s.root_soil > 14'd8000) pest += 10;
      if (pest > 100) pest = 100;
      if (temp >= 2000 && temp <= 2800 && s.air_humidity > 14'd9000) dis = 80;
      else if (temp >= 1800 && temp <= 3000 && s.air_humidity > 14'd8000) dis = 50;
      else if (s.air_humidity > 14'd7500) dis = 25;
      else dis = 0;
      if (s.leaf_wetness > 7'd70) dis += 15;
      if (dis > 100) dis = 100;

      need = 1'b0;
      stop = 1'b0;
      if (model_cfg.root_layer_enabled) begin
         if (s.root_soil < model_cfg.root_soil_min) need = 1'b1;
         if (s.root_soil > model_cfg.root_soil_max) stop = 1'b1;
      end
      if (model_cfg.top_layer_enabled && !need && s.top_soil < model_cfg.top_soil_min)
         need = 1'b1;
      if (model_cfg.weather_adjust) begin
         if (s.rainfall > 16'd20) begin
            need = 1'b0;
            stop = 1'b1;
         end
         if (s.air_humidity > 14'd9000 && need &&
             int'(s.root_soil) > int'(model_cfg.root_soil_min) - 500)
            need = 1'b0;
      end

      model_excess = (s.root_soil > 14'd8500) || (s.top_soil > 14'd9000);
      prior = model_valve;
      elapsed = s.time_ms - model_last_toggle;
      if (elapsed >= model_cfg.min_toggle_ms) begin
         if (!model_irrigating && need) begin
            model_irrigating = 1'b1;
            model_last_toggle = s.time_ms;
         end else if (model_irrigating && stop) begin
            model_irrigating = 1'b0;
            model_last_toggle = s.time_ms;
         end
         model_need = need;
         model_valve = model_irrigating;
      end
      r.valve_changed = 1'b0;
      if (!model_cfg.automatic_mode) model_valve = 1'b0;
      else r.valve_changed = (model_valve != prior);

      r.pest_risk       = 7'(pest);
      r.disease_risk    = 7'(dis);
      r.excess_water    = model_excess;
      r.watering_needed = model_need;
      r.valve_open      = model_valve;
      return r;
   endfunction

   task automatic stage(int temp, int hum, int leaf, int top, int root, int rain,
                        logic [31:0] ms, bit typed, int pest, int dis, bit ex, bit nd,
                        bit vo, bit ch);
      sample_row_type row;
      row.sample.air_temp            = 15'(temp);
      row.sample.air_humidity        = 14'(hum);
      row.sample.leaf_wetness        = 7'(leaf);
      row.sample.top_soil            = 14'(top);
      row.sample.root_soil           = 14'(root);
      row.sample.rainfall            = 16'(rain);
      row.sample.time_ms             = ms;
      row.typed                      = typed;
      row.result.pest_risk           = 7'(pest);
      row.result.disease_risk        = 7'(dis);
      row.result.excess_water        = ex;
      row.result.watering_needed     = nd;
      row.result.valve_open          = vo;
      row.result.valve_changed       = ch;
      directed_rows.push_back(row);
   endtask

   function automatic irr_pkg::req_type random_sample();
      irr_pkg::req_type s;
      case ($urandom_range(0, 9))
         0:       s.air_temp = 15'($urandom);
         1, 2:    s.air_temp = 15'(int'($urandom_range(0, 15000)) - 5000);
         default: s.air_temp = 15'($urandom_range(1700, 3100));
      endcase
      case ($urandom_range(0, 9))
         0:          s.air_humidity = 14'($urandom);
         1, 2, 3:    s.air_humidity = 14'($urandom_range(0, 10000));
         default:    s.air_humidity = 14'($urandom_range(7000, 10000));
      endcase
      s.leaf_wetness = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(0, 100));
      s.top_soil  = ($urandom_range(0, 9) == 0) ? 14'($urandom) : 14'($urandom_range(0, 10000));
      s.root_soil = ($urandom_range(0, 9) == 0) ? 14'($urandom) : 14'($urandom_range(0, 10000));
      case ($urandom_range(0, 9))
         0, 1:    s.rainfall = 16'($urandom);
         2, 3, 4: s.rainfall = 16'($urandom_range(0, 40));
         default: s.rainfall = 16'd0;
      endcase
      case ($urandom_range(0, 9))
         0:       sample_time = $urandom;
         1:       sample_time = sample_time;
         default: sample_time = sample_time + $urandom_range(0, 40000);
      endcase
      s.time_ms = sample_time;
      return s;
   endfunction

   // entered and left at a falling edge
   task automatic send_sample(irr_pkg::req_type s, bit typed, irr_pkg::rsp_type result);
      irr_pkg::rsp_type predicted;
      while (!steady && $urandom_range(0, 99) < 17) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= s;
      do @(posedge clock); while (!req_ch.ready);
      predicted = predict_decision(s);
      expected_decisions.push_back(typed ? result : predicted);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic run_random(int count);
      irr_pkg::rsp_type none;
      none = '0;
      repeat (count) send_sample(random_sample(), 1'b0, none);
   endtask

   task automatic settle_pipeline();
      req_ch.valid <= 1'b0;
      while (expected_decisions.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic apply_settings(irr_pkg::cfg_type c);
      logic [irr_pkg::CSR_DATA_W-1:0] value;
      logic [irr_pkg::CSR_IDX_W-1:0]  idx;
      settle_pipeline();
      for (int i = 0; i < 8; i++) begin
         idx = irr_pkg::CSR_IDX_W'(i);
         value = $urandom;
         case (idx)
            irr_pkg::CSR_TOP_SOIL_MIN:       value[13:0] = c.top_soil_min;
            irr_pkg::CSR_ROOT_SOIL_MIN:      value[13:0] = c.root_soil_min;
            irr_pkg::CSR_ROOT_SOIL_MAX:      value[13:0] = c.root_soil_max;
            irr_pkg::CSR_TOP_LAYER_ENABLED:  value[0] = c.top_layer_enabled;
            irr_pkg::CSR_ROOT_LAYER_ENABLED: value[0] = c.root_layer_enabled;
            irr_pkg::CSR_WEATHER_ADJUST:     value[0] = c.weather_adjust;
            irr_pkg::CSR_AUTOMATIC_MODE:     value[0] = c.automatic_mode;
            irr_pkg::CSR_MIN_TOGGLE_MS:      value = c.min_toggle_ms;
         endcase
         csr_we    <= 1'b1;
         csr_index <= idx;
         csr_wdata <= value;
         @(negedge clock);
      end
      csr_we <= 1'b0;
      model_cfg = c;
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report_mismatch(name, got, want);
   endtask

   // result side: random stalls plus one long hold-off
   always @(negedge clock) begin
      if (!hold_done && items_sent >= 250) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 17);
      end
   end

   always @(posedge clock) begin : check_results
      irr_pkg::rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_decisions.size() == 0) begin
            report_mismatch("result with no sample pending", 1, 0);
         end else begin
            want = expected_decisions.pop_front();
            check_field("pest_risk", rsp_ch.data.pest_risk, want.pest_risk);
            check_field("disease_risk", rsp_ch.data.disease_risk, want.disease_risk);
            check_field("excess_water", rsp_ch.data.excess_water, want.excess_water);
            check_field("watering_needed", rsp_ch.data.watering_needed,
                        want.watering_needed);
            check_field("valve_open", rsp_ch.data.valve_open, want.valve_open);
            check_field("valve_changed", rsp_ch.data.valve_changed, want.valve_changed);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_irrigation_decision_with_risk_top: errors");
         $finish;
      end
   end

   initial begin
      reset        = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      rsp_ch.ready = 1'b0;
      csr_we       = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      model_cfg = make_cfg(irr_pkg::RST_TOP_SOIL_MIN, irr_pkg::RST_ROOT_SOIL_MIN,
                           irr_pkg::RST_ROOT_SOIL_MAX, 1'b1, 1'b1, 1'b1, 1'b1,
                           irr_pkg::RST_MIN_TOGGLE_MS);
      model_irrigating  = 1'b0;
      model_last_toggle = '0;
      model_valve       = 1'b0;
      model_need        = 1'b0;
      model_excess      = 1'b0;
      sample_time       = 32'h0010_0000;

      //     temp    hum    leaf top    root   rain   time          typed  expected
      stage(0,      0,     0,   0,     0,     0,     32'd0,        1, 0,  0,  0, 0, 0, 0);
      stage(10000,  10000, 100, 10000, 10000, 65535, 32'd0,        1, 75, 40, 1, 0, 0, 0);
      stage(-16384, 16383, 127, 16383, 16383, 65535, 32'hFFFFFFFF, 1, 75, 40, 1, 0, 0, 0);
      stage(16383,  0,     0,   0,     0,     0,     32'd1,        1, 0,  0,  0, 0, 0, 0);
      // risk peaks, start, blocked stop, stop
      stage(2500,   9500,  80,  5000,  9000,  0,     32'd60000,    0, 0,  0,  0, 0, 0, 0);
      stage(2000,   5000,  61,  5000,  1000,  0,     32'd120000,   0, 0,  0,  0, 0, 0, 0);
      stage(2500,   5000,  0,   5000,  9000,  0,     32'd150000,   0, 0,  0,  0, 0, 0, 0);
      stage(3000,   8501,  71,  5000,  9000,  0,     32'd180000,   0, 0,  0,  0, 0, 0, 0);
      // rain override, humidity hold with and without the root margin
      stage(1999,   8500,  60,  5000,  1000,  21,    32'd240000,   0, 0,  0,  0, 0, 0, 0);
      stage(3001,   9001,  70,  5000,  3400,  20,    32'd300000,   0, 0,  0,  0, 0, 0, 0);
      stage(2800,   9001,  0,   5000,  3000,  0,     32'd360000,   0, 0,  0,  0, 0, 0, 0);
      stage(2801,   9000,  0,   5000,  7001,  0,     32'd420000,   0, 0,  0,  0, 0, 0, 0);
      // top layer trigger and excess water bounds
      stage(1800,   8001,  0,   2400,  5000,  0,     32'd480000,   0, 0,  0,  0, 0, 0, 0);
      stage(1799,   7501,  0,   9001,  8001,  0,     32'd540000,   0, 0,  0,  0, 0, 0, 0);
      stage(1800,   7500,  0,   9000,  8500,  0,     32'd600000,   0, 0,  0,  0, 0, 0, 0);
      stage(3000,   8000,  0,   2500,  8501,  0,     32'd660000,   0, 0,  0,  0, 0, 0, 0);
      stage(2200,   5000,  0,   2499,  3500,  0,     32'd720000,   0, 0,  0,  0, 0, 0, 0);
      stage(2200,   5000,  0,   5000,  7000,  0,     32'd780000,   0, 0,  0,  0, 0, 0, 0);
      // time wrap around the toggle interval
      stage(2200,   5000,  0,   5000,  7001,  0,     32'hFFFFFFF0, 0, 0,  0,  0, 0, 0, 0);
      stage(2200,   5000,  0,   5000,  1000,  0,     32'h00001000, 0, 0,  0,  0, 0, 0, 0);
      stage(2200,   5000,  0,   5000,  1000,  0,     32'd60000,    0, 0,  0,  0, 0, 0, 0);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_sample(directed_rows[i].sample, directed_rows[i].typed, directed_rows[i].result);
      run_random(150);

      apply_settings(make_cfg(2500, 3500, 7000, 1'b1, 1'b1, 1'b1, 1'b1, 32'd0));
      run_random(150);
      apply_settings(make_cfg(2500, 3500, 7000, 1'b1, 1'b1, 1'b1, 1'b1, 32'hFFFFFFFF));
      run_random(60);
      apply_settings(make_cfg(16383, 0, 16383, 1'b1, 1'b1, 1'b1, 1'b1, 32'd5000));
      run_random(150);
      apply_settings(make_cfg(0, 3500, 7000, 1'b1, 1'b0, 1'b0, 1'b1, 32'd20000));
      run_random(150);
      apply_settings(make_cfg(0, 10000, 0, 1'b0, 1'b1, 1'b1, 1'b1, 32'd20000));
      run_random(150);
      apply_settings(make_cfg(2500, 3500, 7000, 1'b1, 1'b1, 1'b1, 1'b0, 32'd10000));
      run_random(150);
      repeat (2) begin
         apply_settings(make_cfg($urandom_range(0, 16383), $urandom_range(0, 16383),
                                 $urandom_range(0, 16383), 1'($urandom), 1'($urandom),
                                 1'($urandom), 1'b1, $urandom_range(0, 50000)));
         run_random(100);
      end

      settle_pipeline();
      if (mismatches == 0) begin
         $display("tb_irrigation_decision_with_risk_top: clean");
      end else begin
         $display("tb_irrigation_decision_with_risk_top: errors");
      end
      $finish;
   end

endmodule
